FILE: hw/rtl/gfun_pkg.sv
// gfun_pkg: shared widths, types and datapath step functions for the
// grid face unit normal pipeline. No dependencies.
package gfun_pkg;

  localparam int DIV_STEPS = 31;               // quotient bits of 2^30*n^2/s
  localparam int SQRT_STEPS = 16;              // root bits of a 32-bit radicand
  localparam int LANE_LAT = DIV_STEPS + SQRT_STEPS;
  localparam int NUM_W = 64;
  localparam int DEN_W = 65;
  localparam int QUO_W = 31;
  localparam int ROOT_W = 16;
  localparam int REM_W = 18;
  localparam logic [14:0] MAG_MAX = 15'h7fff;

  // per-item flags that ride alongside the lanes
  typedef struct packed {
    logic deg_e;
    logic deg_n;
    logic neg_enx;
    logic neg_eny;
    logic neg_nnx;
    logic neg_nny;
  } side_t;

  // front end result handed to the four lanes
  typedef struct packed {
    side_t side;
    logic [NUM_W-1:0] ex2;
    logic [NUM_W-1:0] ey2;
    logic [NUM_W-1:0] nx2;
    logic [NUM_W-1:0] ny2;
    logic [DEN_W-1:0] se;
    logic [DEN_W-1:0] sn;
  } front_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic q_bit;
  } div_res_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_res_t;

  // one restoring division step: t is the shifted partial remainder
  function automatic div_res_t div_step(input logic [DEN_W:0] t,
                                        input logic [DEN_W-1:0] s);
    div_res_t r;
    logic [DEN_W:0] d;
    d = t - {1'b0, s};
    if (t >= {1'b0, s}) begin
      r.q_bit = 1'b1;
      r.rem = d[DEN_W-1:0];
    end else begin
      r.q_bit = 1'b0;
      r.rem = t[DEN_W-1:0];
    end
    return r;
  endfunction

  // one restoring square root step, two radicand bits in
  function automatic sqrt_res_t sqrt_step(input logic [REM_W-1:0] rem,
                                          input logic [ROOT_W-1:0] root,
                                          input logic [1:0] pair);
    sqrt_res_t r;
    logic [REM_W+1:0] acc;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    acc = {rem, pair};
    trial = {2'b00, root, 2'b01};
    diff = acc - trial;
    if (acc >= trial) begin
      r.rem = diff[REM_W-1:0];
      r.root = {root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem = acc[REM_W-1:0];
      r.root = {root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/gfun_front.sv
// gfun_front: edge differences, magnitudes, squares and squared lengths.
// Four register stages. Depends on gfun_pkg.
module gfun_front import gfun_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vld_in,
  input  logic [31:0]  x_here,
  input  logic [31:0]  y_here,
  input  logic [31:0]  x_back_j,
  input  logic [31:0]  y_back_j,
  input  logic [31:0]  x_back_i,
  input  logic [31:0]  y_back_i,
  output logic         vld_out,
  output front_t       fo
);

  logic [3:0]  vld_r;
  logic [32:0] edx_r, edy_r, ndx_r, ndy_r;
  logic [31:0] eax_r, eay_r, nax_r, nay_r;
  side_t       side2_r, side3_r, side4_r;
  logic [63:0] ex2_r, ey2_r, nx2_r, ny2_r;
  logic [63:0] ex2_4_r, ey2_4_r, nx2_4_r, ny2_4_r;
  logic [64:0] se_r, sn_r;
  logic [32:0] edx_a, edy_a, ndx_a, ndy_a;
  side_t       side_nxt;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_in};
    end
  end

  // stage 1: 33-bit edge differences
  always_ff @(posedge clk) begin
    if (en) begin
      edx_r <= {x_here[31], x_here} - {x_back_j[31], x_back_j};
      edy_r <= {y_here[31], y_here} - {y_back_j[31], y_back_j};
      ndx_r <= {x_back_i[31], x_back_i} - {x_here[31], x_here};
      ndy_r <= {y_back_i[31], y_back_i} - {y_here[31], y_here};
    end
  end

  // stage 2: magnitudes and sign flags
  assign edx_a = edx_r[32] ? (~edx_r + 33'd1) : edx_r;
  assign edy_a = edy_r[32] ? (~edy_r + 33'd1) : edy_r;
  assign ndx_a = ndx_r[32] ? (~ndx_r + 33'd1) : ndx_r;
  assign ndy_a = ndy_r[32] ? (~ndy_r + 33'd1) : ndy_r;

  always_comb begin
    side_nxt.deg_e   = (edx_r == '0) && (edy_r == '0);
    side_nxt.deg_n   = (ndx_r == '0) && (ndy_r == '0);
    side_nxt.neg_enx = edy_r[32];
    side_nxt.neg_eny = !edx_r[32] && (edx_r != '0);
    side_nxt.neg_nnx = ndy_r[32];
    side_nxt.neg_nny = !ndx_r[32] && (ndx_r != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eax_r   <= edx_a[31:0];
      eay_r   <= edy_a[31:0];
      nax_r   <= ndx_a[31:0];
      nay_r   <= ndy_a[31:0];
      side2_r <= side_nxt;
    end
  end

  // stage 3: one 32x32 square per magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      ex2_r   <= eax_r * eax_r;
      ey2_r   <= eay_r * eay_r;
      nx2_r   <= nax_r * nax_r;
      ny2_r   <= nay_r * nay_r;
      side3_r <= side2_r;
    end
  end

  // stage 4: squared edge lengths
  always_ff @(posedge clk) begin
    if (en) begin
      se_r    <= {1'b0, ex2_r} + {1'b0, ey2_r};
      sn_r    <= {1'b0, nx2_r} + {1'b0, ny2_r};
      ex2_4_r <= ex2_r;
      ey2_4_r <= ey2_r;
      nx2_4_r <= nx2_r;
      ny2_4_r <= ny2_r;
      side4_r <= side3_r;
    end
  end

  assign vld_out = vld_r[3];
  assign fo.side = side4_r;
  assign fo.ex2  = ex2_4_r;
  assign fo.ey2  = ey2_4_r;
  assign fo.nx2  = nx2_4_r;
  assign fo.ny2  = ny2_4_r;
  assign fo.se   = se_r;
  assign fo.sn   = sn_r;

endmodule

FILE: hw/rtl/gfun_lane.sv
// gfun_lane: one normal component magnitude, isqrt(floor(2^30*num/den)).
// Pipelined restoring divider then restoring square root. Depends on gfun_pkg.
module gfun_lane import gfun_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic [ROOT_W-1:0] root
);

  logic [DEN_W-1:0]  div_rem_r [DIV_STEPS];
  logic [DEN_W-1:0]  div_den_r [DIV_STEPS];
  logic [QUO_W-1:0]  div_quo_r [DIV_STEPS];
  logic [REM_W-1:0]  sq_rem_r  [SQRT_STEPS];
  logic [ROOT_W-1:0] sq_root_r [SQRT_STEPS];
  logic [QUO_W-1:0]  sq_val_r  [SQRT_STEPS];

  // divider: one quotient bit per stage, msb first
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [DEN_W:0]   t;
    logic [DEN_W-1:0] s;
    logic [QUO_W-1:0] q_prev;
    div_res_t         dr;
    if (k == 0) begin : g_first
      assign t      = {1'b0, 1'b0, num};
      assign s      = den;
      assign q_prev = '0;
    end else begin : g_next
      assign t      = {div_rem_r[k-1], 1'b0};
      assign s      = div_den_r[k-1];
      assign q_prev = div_quo_r[k-1];
    end
    assign dr = div_step(t, s);
    always_ff @(posedge clk) begin
      if (en) begin
        div_rem_r[k] <= dr.rem;
        div_den_r[k] <= s;
        div_quo_r[k] <= {q_prev[QUO_W-2:0], dr.q_bit};
      end
    end
  end

  // square root: one root bit per stage
  for (genvar m = 0; m < SQRT_STEPS; m++) begin : g_sqrt
    logic [REM_W-1:0]  rem_prev;
    logic [ROOT_W-1:0] root_prev;
    logic [QUO_W-1:0]  val;
    logic [QUO_W:0]    pad;
    sqrt_res_t         sr;
    if (m == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign val       = div_quo_r[DIV_STEPS-1];
    end else begin : g_next
      assign rem_prev  = sq_rem_r[m-1];
      assign root_prev = sq_root_r[m-1];
      assign val       = sq_val_r[m-1];
    end
    assign pad = {1'b0, val};
    assign sr  = sqrt_step(rem_prev, root_prev, pad[QUO_W-2*m -: 2]);
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[m]  <= sr.rem;
        sq_root_r[m] <= sr.root;
        sq_val_r[m]  <= val;
      end
    end
  end

  assign root = sq_root_r[SQRT_STEPS-1];

endmodule

FILE: hw/rtl/grid_face_unit_normals.sv
// Channel   | Direction | Ports
// ----------+-----------+-------------------------------------------------
// in        | request   | in_valid, in_stall, in_x_here .. in_y_back_i
// out       | result    | out_valid, out_stall, out_east_nx .. degenerate
//
// One request per cycle enters while no result is held; it passes through
// 4 front stages, 31 divider stages, 16 root stages and 1 output register.
// Synchronous active-low reset clears only the valid bits.
// A stalled result freezes the whole pipeline; nothing is dropped.
// Top level: east and north face unit normals. Depends on gfun_pkg,
// gfun_front and gfun_lane.
module grid_face_unit_normals import gfun_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_x_here,
  input  logic [31:0] in_y_here,
  input  logic [31:0] in_x_back_j,
  input  logic [31:0] in_y_back_j,
  input  logic [31:0] in_x_back_i,
  input  logic [31:0] in_y_back_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_east_nx,
  output logic [15:0] out_east_ny,
  output logic [15:0] out_north_nx,
  output logic [15:0] out_north_ny,
  output logic        out_east_degenerate,
  output logic        out_north_degenerate
);

  logic          en;
  logic          fr_vld;
  front_t        fo;
  logic [ROOT_W-1:0] r_enx, r_eny, r_nnx, r_nny;
  logic [LANE_LAT-1:0] vld_r;
  side_t         side_r [LANE_LAT];
  side_t         sd;
  logic          out_valid_r;
  logic [15:0]   enx_r, eny_r, nnx_r, nny_r;
  logic          edeg_r, ndeg_r;

  // pipeline advances unless a finished result is held
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  gfun_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (in_valid),
    .x_here   (in_x_here),
    .y_here   (in_y_here),
    .x_back_j (in_x_back_j),
    .y_back_j (in_y_back_j),
    .x_back_i (in_x_back_i),
    .y_back_i (in_y_back_i),
    .vld_out  (fr_vld),
    .fo       (fo)
  );

  // nx takes |dy| as numerator, ny takes |dx|
  gfun_lane u_lane_enx (.clk(clk), .en(en), .num(fo.ey2), .den(fo.se), .root(r_enx));
  gfun_lane u_lane_eny (.clk(clk), .en(en), .num(fo.ex2), .den(fo.se), .root(r_eny));
  gfun_lane u_lane_nnx (.clk(clk), .en(en), .num(fo.ny2), .den(fo.sn), .root(r_nnx));
  gfun_lane u_lane_nny (.clk(clk), .en(en), .num(fo.nx2), .den(fo.sn), .root(r_nny));

  // valid and flag delay lines matching the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LANE_LAT-2:0], fr_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= fo.side;
      for (int k = 1; k < LANE_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign sd = side_r[LANE_LAT-1];

  // saturate, apply sign, zero degenerate edges
  function automatic logic [15:0] fmt(input logic [ROOT_W-1:0] r, input logic neg,
                                      input logic deg);
    logic [14:0] mag;
    logic [15:0] v;
    mag = r[ROOT_W-1] ? MAG_MAX : r[14:0];
    v = {1'b0, mag};
    if (deg) begin
      v = '0;
    end else if (neg) begin
      v = ~v + 16'd1;
    end
    return v;
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      enx_r  <= fmt(r_enx, sd.neg_enx, sd.deg_e);
      eny_r  <= fmt(r_eny, sd.neg_eny, sd.deg_e);
      nnx_r  <= fmt(r_nnx, sd.neg_nnx, sd.deg_n);
      nny_r  <= fmt(r_nny, sd.neg_nny, sd.deg_n);
      edeg_r <= sd.deg_e;
      ndeg_r <= sd.deg_n;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_east_nx          = enx_r;
  assign out_east_ny          = eny_r;
  assign out_north_nx         = nnx_r;
  assign out_north_ny         = nny_r;
  assign out_east_degenerate  = edeg_r;
  assign out_north_degenerate = ndeg_r;

endmodule

FILE: hw/rtl/gfun_checker.sv
// gfun_checker: port-level assertions for grid_face_unit_normals, and the
// bind that attaches them. Depends on the top level's ports only.
module gfun_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_east_nx,
  input logic [15:0] out_east_ny,
  input logic [15:0] out_north_nx,
  input logic [15:0] out_north_ny,
  input logic        out_east_degenerate,
  input logic        out_north_degenerate
);

  // a held result stays valid and keeps its east nx and north ny
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_east_nx) && $stable(out_north_ny))
    else $error("held result changed");

  // input stalls exactly when a result is held
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");

  // degenerate east edges give a zero normal
  a_deg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_east_degenerate |-> out_east_nx == 16'h0 && out_east_ny == 16'h0)
    else $error("degenerate east normal not zero");

  // a real north edge never gives a zero normal
  a_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_north_degenerate |-> out_north_nx != 16'h0 || out_north_ny != 16'h0)
    else $error("north normal vanished");

  // saturation keeps every component off the most negative code
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_east_nx != 16'h8000 && out_east_ny != 16'h8000 &&
                  out_north_nx != 16'h8000 && out_north_ny != 16'h8000)
    else $error("component out of range");

endmodule

bind grid_face_unit_normals gfun_checker u_gfun_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_east_nx          (out_east_nx),
  .out_east_ny          (out_east_ny),
  .out_north_nx         (out_north_nx),
  .out_north_ny         (out_north_ny),
  .out_east_degenerate  (out_east_degenerate),
  .out_north_degenerate (out_north_degenerate)
);

FILE: dv/tb_grid_face_unit_normals.sv
// Self-checking testbench for grid_face_unit_normals: east and north face unit normals.
// A queue-fed driver and an output monitor check each result against a local predictor.
// Depends on the grid_face_unit_normals RTL only.
`timescale 1ns / 100ps

module tb_grid_face_unit_normals;

  localparam int PIPE_DEPTH = 52;
  localparam int HANG_LIMIT = 4000;
  localparam int N_RANDOM   = 400;
  localparam int CALM_TAIL  = 60;

  typedef struct {
    logic [31:0] xh, yh, xj, yj, xi, yi;
  } cell_t;

  typedef struct {
    logic [15:0] enx, eny, nnx, nny;
    logic        edeg, ndeg;
  } normals_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_x_here, in_y_here, in_x_back_j, in_y_back_j, in_x_back_i, in_y_back_i;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_east_nx, out_east_ny, out_north_nx, out_north_ny;
  logic        out_east_degenerate, out_north_degenerate;

  cell_t    cell_queue[$];
  normals_t normals_due[$];
  int       n_errors = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_degen = 0;
  int       in_gap = 0;
  int       out_gap = 0;
  int       idle_cycles = 0;
  bit       stim_done = 0;

  grid_face_unit_normals dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x_here(in_x_here), .in_y_here(in_y_here),
    .in_x_back_j(in_x_back_j), .in_y_back_j(in_y_back_j),
    .in_x_back_i(in_x_back_i), .in_y_back_i(in_y_back_i),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_east_nx(out_east_nx), .out_east_ny(out_east_ny),
    .out_north_nx(out_north_nx), .out_north_ny(out_north_ny),
    .out_east_degenerate(out_east_degenerate),
    .out_north_degenerate(out_north_degenerate)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Largest q in [0,32768] with q/32768 <= num/sqrt(num^2+oth^2), capped at 32767
  function automatic logic [15:0] unit_mag(logic [63:0] num, logic [63:0] oth);
    logic [31:0]  lo_q, hi_q, q;
    logic [127:0] lhs, rhs, qb;
    lo_q = 0;
    hi_q = 32768;
    while (lo_q < hi_q) begin
      q = (lo_q + hi_q + 1) >> 1;
      qb = 128'(q) * 128'(oth);
      lhs = qb * qb;
      rhs = (128'(num) * 128'(num)) * (128'(1 << 30) - 128'(q) * 128'(q));
      if (lhs <= rhs) lo_q = q;
      else hi_q = q - 1;
    end
    return (lo_q > 32767) ? 16'd32767 : lo_q[15:0];
  endfunction

  // Normal (dy/len, -dx/len) of one edge; zero-length edges are flagged
  function automatic void edge_unit_normal(logic signed [32:0] dx, logic signed [32:0] dy,
                                           output logic [15:0] nx, output logic [15:0] ny,
                                           output logic deg);
    logic [63:0] ax, ay;
    logic [15:0] mx, my;
    ax = (dx < 0) ? 64'(-dx) : 64'(dx);
    ay = (dy < 0) ? 64'(-dy) : 64'(dy);
    deg = (ax == 0) && (ay == 0);
    if (deg) begin
      nx = '0;
      ny = '0;
    end else begin
      mx = unit_mag(ay, ax);
      my = unit_mag(ax, ay);
      nx = (dy < 0) ? -mx : mx;
      ny = (dx > 0) ? -my : my;
    end
  endfunction

  function automatic normals_t cell_normals(cell_t c);
    normals_t r;
    edge_unit_normal(33'(signed'(c.xh)) - 33'(signed'(c.xj)),
                     33'(signed'(c.yh)) - 33'(signed'(c.yj)), r.enx, r.eny, r.edeg);
    edge_unit_normal(33'(signed'(c.xi)) - 33'(signed'(c.xh)),
                     33'(signed'(c.yi)) - 33'(signed'(c.yh)), r.nnx, r.nny, r.ndeg);
    return r;
  endfunction

  function automatic cell_t mk_cell(logic [31:0] xh, yh, xj, yj, xi, yi);
    cell_t c;
    c.xh = xh; c.yh = yh; c.xj = xj; c.yj = yj; c.xi = xi; c.yi = yi;
    return c;
  endfunction

  function automatic logic [31:0] near(logic [31:0] base);
    return base + 32'($signed($urandom_range(0, 8192)) - 4096);
  endfunction

  // Request driver
  always @(posedge clk) begin
    cell_t nxt;
    bit    present;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        normals_due.push_back(cell_normals(cell_queue.pop_front()));
        n_sent++;
      end
      present = 0;
      if (in_valid && in_stall) begin
        present = 1;
      end else if (in_gap > 0) begin
        in_gap--;
      end else if (cell_queue.size() > 0) begin
        if (cell_queue.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
          in_gap = $urandom_range(1, 19);
        else
          present = 1;
      end
      in_valid <= present;
      if (present) begin
        nxt = cell_queue[0];
        in_x_here   <= nxt.xh;
        in_y_here   <= nxt.yh;
        in_x_back_j <= nxt.xj;
        in_y_back_j <= nxt.yj;
        in_x_back_i <= nxt.xi;
        in_y_back_i <= nxt.yi;
      end
    end
  end

  // Result monitor and back-pressure
  always @(posedge clk) begin
    normals_t exp_n;
    if (rst_n && out_valid && !out_stall) begin
      if (normals_due.size() == 0) begin
        $error("result with no request outstanding");
        n_errors++;
      end else begin
        exp_n = normals_due.pop_front();
        n_checked++;
        if (exp_n.edeg || exp_n.ndeg) n_degen++;
        if (out_east_nx !== exp_n.enx) begin
          $error("east_nx exp %h got %h", exp_n.enx, out_east_nx); n_errors++;
        end
        if (out_east_ny !== exp_n.eny) begin
          $error("east_ny exp %h got %h", exp_n.eny, out_east_ny); n_errors++;
        end
        if (out_north_nx !== exp_n.nnx) begin
          $error("north_nx exp %h got %h", exp_n.nnx, out_north_nx); n_errors++;
        end
        if (out_north_ny !== exp_n.nny) begin
          $error("north_ny exp %h got %h", exp_n.nny, out_north_ny); n_errors++;
        end
        if (out_east_degenerate !== exp_n.edeg) begin
          $error("east_degenerate exp %b got %b", exp_n.edeg, out_east_degenerate);
          n_errors++;
        end
        if (out_north_degenerate !== exp_n.ndeg) begin
          $error("north_degenerate exp %b got %b", exp_n.ndeg, out_north_degenerate);
          n_errors++;
        end
      end
    end
    if (!rst_n || cell_queue.size() <= CALM_TAIL) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= (out_gap != 0);
    end else if ($urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(1, 19);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: cycles with no request or result moving
  always @(posedge clk) begin
    if (rst_n && !stim_done) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int   sel;
    logic [31:0] bx, by;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    {in_x_here, in_y_here, in_x_back_j, in_y_back_j, in_x_back_i, in_y_back_i} = '0;

    // directed: degenerate edges, axis-aligned edges, extremes, diagonals
    cell_queue.push_back(mk_cell(0, 0, 0, 0, 0, 0));
    cell_queue.push_back(mk_cell(32'h10000, 0, 0, 0, 32'h10000, 32'h10000));
    cell_queue.push_back(mk_cell(0, 0, 32'h10000, 0, 0, 32'hffff0000));
    cell_queue.push_back(mk_cell(0, 32'h10000, 0, 0, 32'hffff0000, 32'h10000));
    cell_queue.push_back(mk_cell(0, 0, 0, 32'h10000, 0, 0));
    cell_queue.push_back(mk_cell(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                                 32'h80000000, 32'h80000000));
    cell_queue.push_back(mk_cell(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                 32'h7fffffff, 32'h7fffffff));
    cell_queue.push_back(mk_cell(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                 32'h7fffffff, 32'h80000000));
    cell_queue.push_back(mk_cell(32'h7fffffff, 0, 32'h80000000, 0, 32'h7fffffff, 32'h80000000));
    cell_queue.push_back(mk_cell(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                                 32'hffffffff, 32'hffffffff));
    cell_queue.push_back(mk_cell(1, 0, 0, 0, 1, 1));
    cell_queue.push_back(mk_cell(1, 1, 0, 0, 0, 2));
    cell_queue.push_back(mk_cell(0, 0, 32'h7fffffff, 1, 1, 32'h7fffffff));
    cell_queue.push_back(mk_cell(32'h30000, 32'h40000, 0, 0, 32'h30000, 32'h40000));
    cell_queue.push_back(mk_cell(0, 0, 32'h30000, 32'h40000, 32'hfffd0000, 32'h40000));
    cell_queue.push_back(mk_cell(5, 0, 0, 32'hffffffff, 32'h80000000, 0));

    // random: mostly neighbouring grid corners, some full-range and degenerate ones
    for (int k = 0; k < N_RANDOM; k++) begin
      sel = $urandom_range(0, 9);
      bx = $urandom();
      by = $urandom();
      if (sel < 6)
        cell_queue.push_back(mk_cell(bx, by, near(bx), near(by), near(bx), near(by)));
      else if (sel < 9)
        cell_queue.push_back(mk_cell(bx, by, $urandom(), $urandom(), $urandom(), $urandom()));
      else
        cell_queue.push_back(mk_cell(bx, by, bx, by, ($urandom_range(0, 1) ? bx : near(bx)),
                                     by));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (cell_queue.size() != 0 || normals_due.size() != 0) @(posedge clk);
    stim_done = 1;
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (normals_due.size() != 0) begin
      $error("%0d results never arrived", normals_due.size());
      n_errors++;
    end

    $display("sent %0d cells, checked %0d results (%0d with a zero-length edge)",
             n_sent, n_checked, n_degen);
    $display("both channels throttled at random before a calm tail; %0d mismatches",
             n_errors);
    if (n_errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
